@@ hdl/gss_pkg.sv @@
// Shared constants, status codes and helpers for the Gauss-Seidel solver.
// No dependencies.
package gss_pkg;
   localparam int SIZE_DEF      = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int TOL_W         = 16;
   localparam int LIM_W         = 10;
   localparam int VAL_W         = 32;
   localparam int ROW_W         = 2;
   localparam int COL_W         = 3;
   localparam int ST_W          = 2;
   localparam int ACC_W         = 128;

   localparam logic [ST_W-1:0] ST_CONVERGED = 2'd0;
   localparam logic [ST_W-1:0] ST_LIMIT     = 2'd1;
   localparam logic [ST_W-1:0] ST_ZERO_DIAG = 2'd2;

   localparam logic [1:0] REG_TOLERANCE   = 2'd0;
   localparam logic [1:0] REG_SWEEP_LIMIT = 2'd1;

   // One entry of the front-to-back queue
   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        column;
      logic signed [VAL_W-1:0] coefficient;
      logic                    start_solve;
   } item_type;
endpackage

@@ hdl/gss_front.sv @@
// Input side of the solver: accepts words and holds them in a short queue.
// Depends on gss_pkg.
module gss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  gss_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_take,
   output gss_pkg::item_type q_item
);
   import gss_pkg::*;

   item_type  mem_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_stall = (cnt_ff == 2'd2);
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_take;
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

@@ hdl/gss_div.sv @@
// Restoring divider: signed 128-bit dividend by signed 32-bit divisor,
// one quotient bit a cycle, result saturated to 32 bits. Depends on gss_pkg.
module gss_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gss_pkg::ACC_W-1:0]   dividend,
   input  logic signed [gss_pkg::VAL_W-1:0] divisor,
   output logic                        done,
   output logic signed [gss_pkg::VAL_W-1:0] quotient
);
   import gss_pkg::*;

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic [ACC_W-1:0]  num_ff, num_in, q_ff, q_in;
   logic [VAL_W:0]    rem_ff, rem_in, trial;
   logic [VAL_W-1:0]  dm_ff, dm_in;
   logic              neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VAL_W:0]    shifted;
   logic [ACC_W-1:0]  qmag;

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff[VAL_W-1:0], num_ff[ACC_W-1]};
      trial   = shifted - {1'b0, dm_ff};
      if (start) begin
         num_in  = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
         dm_in   = divisor[VAL_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[ACC_W-1] ^ divisor[VAL_W-1];
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CNT_W'(ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[ACC_W-2:0], 1'b0};
         if (!trial[VAL_W]) begin
            rem_in = trial;
            q_in   = {q_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[ACC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // saturate the magnitude according to the sign
   assign qmag = q_ff;
   always_comb begin
      if (neg_ff) begin
         if (qmag[ACC_W-1:VAL_W] != '0 || qmag[VAL_W-1:0] > 32'h8000_0000)
            quotient = 32'sh8000_0000;
         else
            quotient = -$signed(qmag[VAL_W-1:0]);
      end else begin
         if (qmag[ACC_W-1:VAL_W-1] != '0)
            quotient = 32'sh7FFF_FFFF;
         else
            quotient = $signed(qmag[VAL_W-1:0]);
      end
   end
   assign done = done_ff;
endmodule

@@ hdl/gss_back.sv @@
// Solve engine: coefficient store, sweep sequencer, shared multiplier and
// divider, and the result register. Depends on gss_pkg and gss_div.
module gss_back #(
   parameter int FRAC_BITS = gss_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_take,
   input  gss_pkg::item_type             q_item,
   input  logic [gss_pkg::TOL_W-1:0]     tolerance,
   input  logic [gss_pkg::LIM_W-1:0]     sweep_limit,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [gss_pkg::ROW_W-1:0]     out_index,
   output logic signed [gss_pkg::VAL_W-1:0] out_value,
   output logic [gss_pkg::ST_W-1:0]      out_status,
   output logic [gss_pkg::LIM_W-1:0]     out_sweeps,
   output logic                          out_last
);
   import gss_pkg::*;

   localparam int SIZE  = SIZE_DEF;
   localparam int DEPTH = SIZE * (SIZE + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(SIZE);
   localparam int JW    = $clog2(SIZE + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_WAIT = 3'd5;
   localparam logic [2:0] S_UPD  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic signed [VAL_W-1:0] store [DEPTH];
   logic signed [VAL_W-1:0] rd_ff, diag_ff, diag_in;
   logic [AW-1:0]           rd_addr;
   logic signed [VAL_W-1:0] x_ff [SIZE];
   logic [2:0]              st_ff, st_in;
   logic [IW-1:0]           i_ff, i_in;
   logic [JW-1:0]           j_ff, j_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [2*VAL_W-1:0] prod_ff, prod_in;
   logic [LIM_W-1:0]        sw_ff, sw_in;
   logic                    ok_ff, ok_in;
   logic [ST_W-1:0]         stat_ff, stat_in;
   logic                    x_clr, x_wr;
   logic                    div_start, div_done;
   logic signed [VAL_W-1:0] div_q;
   logic signed [VAL_W:0]   diff;
   logic [VAL_W:0]          adiff;
   logic                    write_item;
   logic [ROW_W-1:0]        oidx_ff, oidx_in;
   logic                    ov_ff, ov_in;
   logic signed [VAL_W-1:0] xj;

   assign write_item = q_take && (32'(q_item.row) < SIZE) && (32'(q_item.column) <= SIZE);
   assign rd_addr    = AW'(32'(i_ff) * (SIZE + 1) + 32'(j_ff));
   assign xj         = (32'(j_ff) < SIZE) ? x_ff[IW'(j_ff)] : '0;

   always_ff @(posedge clock) begin
      if (write_item)
         store[AW'(32'(q_item.row) * (SIZE + 1) + 32'(q_item.column))] <= q_item.coefficient;
      rd_ff <= store[rd_addr];
   end

   gss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (diag_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign diff  = {div_q[VAL_W-1], div_q} - {x_ff[i_ff][VAL_W-1], x_ff[i_ff]};
   assign adiff = diff[VAL_W] ? (~diff + 1'b1) : diff;

   always_comb begin
      st_in     = st_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      diag_in   = diag_ff;
      sw_in     = sw_ff;
      ok_in     = ok_ff;
      stat_in   = stat_ff;
      oidx_in   = oidx_ff;
      ov_in     = ov_ff;
      q_take    = 1'b0;
      x_clr     = 1'b0;
      x_wr      = 1'b0;
      div_start = 1'b0;
      if (ov_ff && !out_stall) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            q_take = q_valid;
            if (q_valid && q_item.start_solve) begin
               x_clr = 1'b1;
               sw_in = '0;
               i_in  = '0;
               j_in  = JW'(SIZE);
               acc_in = '0;
               ok_in = 1'b1;
               if (sweep_limit == '0) begin
                  stat_in = ST_LIMIT;
                  oidx_in = '0;
                  st_in   = S_OUT;
               end else begin
                  st_in = S_RD;
               end
            end
         end
         S_RD: st_in = S_MUL;
         S_MUL: begin
            // constant term scaled up, others are products with the unknowns
            if (32'(j_ff) == SIZE)
               prod_in = 64'(rd_ff) <<< FRAC_BITS;
            else
               prod_in = rd_ff * xj;
            if (j_ff == JW'(i_ff)) diag_in = rd_ff;
            st_in = S_ACC;
         end
         S_ACC: begin
            if (32'(j_ff) == SIZE)
               acc_in = {{(ACC_W-2*VAL_W){prod_ff[2*VAL_W-1]}}, prod_ff};
            else if (j_ff != JW'(i_ff))
               acc_in = acc_ff - {{(ACC_W-2*VAL_W){prod_ff[2*VAL_W-1]}}, prod_ff};
            if (32'(j_ff) == SIZE) j_in = '0;
            else j_in = j_ff + 1'b1;
            if (32'(j_ff) == SIZE - 1) st_in = S_DIV;
            else st_in = S_RD;
         end
         S_DIV: begin
            if (diag_ff == '0) begin
               stat_in = ST_ZERO_DIAG;
               oidx_in = '0;
               st_in   = S_OUT;
            end else begin
               div_start = 1'b1;
               st_in     = S_WAIT;
            end
         end
         S_WAIT: if (div_done) st_in = S_UPD;
         S_UPD: begin
            x_wr = 1'b1;
            if (adiff > (VAL_W+1)'(tolerance)) ok_in = 1'b0;
            j_in = JW'(SIZE);
            if (32'(i_ff) == SIZE - 1) begin
               i_in  = '0;
               sw_in = sw_ff + 1'b1;
               oidx_in = '0;
               if (ok_in) begin
                  stat_in = ST_CONVERGED;
                  st_in   = S_OUT;
               end else if (sw_ff + 1'b1 >= sweep_limit) begin
                  stat_in = ST_LIMIT;
                  st_in   = S_OUT;
               end else begin
                  ok_in = 1'b1;
                  st_in = S_RD;
               end
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = S_RD;
            end
         end
         S_OUT: begin
            if (!ov_ff || !out_stall) begin
               ov_in = 1'b1;
               oidx_in = oidx_ff;
               if (32'(oidx_ff) == SIZE - 1) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         sw_ff <= '0;
         ok_ff <= 1'b1;
         for (int k = 0; k < SIZE; k++) x_ff[k] <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         sw_ff <= sw_in;
         ok_ff <= ok_in;
         if (x_clr) for (int k = 0; k < SIZE; k++) x_ff[k] <= '0;
         else if (x_wr) x_ff[i_ff] <= div_q;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      diag_ff <= diag_in;
      stat_ff <= stat_in;
      // load the output word and step the index
      if (st_ff == S_OUT && (!ov_ff || !out_stall)) begin
         out_index  <= oidx_ff;
         out_value  <= x_ff[IW'(oidx_ff)];
         out_status <= stat_ff;
         out_sweeps <= sw_ff;
         out_last   <= (32'(oidx_ff) == SIZE - 1);
         oidx_ff    <= oidx_ff + 1'b1;
      end else begin
         oidx_ff <= oidx_in;
      end
   end

   assign out_valid = ov_ff;
endmodule

@@ hdl/gauss_seidel_solver_top.sv @@
// Top level of the Gauss-Seidel solver: register port, front queue and engine.
// Depends on gss_pkg, gss_front, gss_back.
//
//   channel  direction  handshake
//   req_     in         req_valid / req_stall
//   rsp_     out        rsp_valid / rsp_stall
//   p        in         APB write/read, pready tied high
//
// A coefficient word is taken each cycle into a two-entry queue, unless the queue
// is full and req_stall is high. A solve is paced by the one shared multiplier and
// the bit-serial 128-step divider; then SIZE result words leave one a cycle while
// rsp_stall is low. Reset is synchronous and clears control state; the
// coefficient store is undefined until written. rsp_stall holds the output.
module gauss_seidel_solver_top #(
   parameter int FRAC_BITS = gss_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [gss_pkg::ROW_W-1:0] req_row,
   input  logic [gss_pkg::COL_W-1:0] req_column,
   input  logic signed [gss_pkg::VAL_W-1:0] req_coefficient,
   input  logic        req_start_solve,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [gss_pkg::ROW_W-1:0] rsp_unknown_index,
   output logic signed [gss_pkg::VAL_W-1:0] rsp_unknown_value,
   output logic [gss_pkg::ST_W-1:0]  rsp_status,
   output logic [gss_pkg::LIM_W-1:0] rsp_sweeps_done,
   output logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import gss_pkg::*;

   logic [TOL_W-1:0] tol_ff;
   logic [LIM_W-1:0] lim_ff;
   item_type         in_item, q_item;
   logic             q_valid, q_take;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
         lim_ff <= LIM_W'(1000);
      end else if (psel && penable && pwrite) begin
         if (paddr[2:2] == REG_TOLERANCE[0:0] && paddr[1:0] == 2'b00)
            tol_ff <= pwdata[TOL_W-1:0];
         else if (paddr[2:2] == REG_SWEEP_LIMIT[0:0] && paddr[1:0] == 2'b00)
            lim_ff <= pwdata[LIM_W-1:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr == {REG_TOLERANCE[0], 2'b00}) prdata = {16'd0, tol_ff};
      else if (paddr == {REG_SWEEP_LIMIT[0], 2'b00}) prdata = {22'd0, lim_ff};
   end

   assign in_item = '{row: req_row, column: req_column,
                      coefficient: req_coefficient, start_solve: req_start_solve};

   gss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_item   (q_item)
   );

   gss_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_item      (q_item),
      .tolerance   (tol_ff),
      .sweep_limit (lim_ff),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_index   (rsp_unknown_index),
      .out_value   (rsp_unknown_value),
      .out_status  (rsp_status),
      .out_sweeps  (rsp_sweeps_done),
      .out_last    (rsp_last_result)
   );
endmodule
